// ===== sv/pgp_pkg.sv =====
// shared constants and types of the polar gaussian pair generator
`default_nettype none
package pgp_pkg;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LOG_FRAC = 24;
    localparam int DIV_STAGES = 31;
    localparam int SQRT_ITERS = 31;
    localparam int SQRT_STAGES = 16;
    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
    localparam logic signed [15:0] MEAN_RESET = 16'sd19200;
    localparam logic [14:0] DEV_RESET = 15'd3072;
    localparam logic REG_MEAN = 1'b0;
    localparam logic REG_DEV = 1'b1;

    typedef struct packed {
        logic [1:0]  neg;
        logic [29:0] sq_a;
        logic [29:0] sq_b;
        logic [29:0] s;
    } pgp_side_t;
endpackage
`default_nettype wire

// ===== sv/pgp_log.sv =====
// pipelined -2 ln s unit: normalize, repeated squaring, scale by 2 ln 2
`default_nettype none
module pgp_log (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire pgp_pkg::pgp_side_t in_side,
    output logic                   out_valid,
    output logic [29:0]            out_t,
    output pgp_pkg::pgp_side_t     out_side
);
    import pgp_pkg::*;

    logic              v_reg    [0:LOG_FRAC];
    logic [30:0]       m_reg    [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] frac_reg [0:LOG_FRAC];
    logic [4:0]        ip_reg   [0:LOG_FRAC];
    pgp_side_t         side_reg [0:LOG_FRAC];
    logic [30:0]       m_next   [1:LOG_FRAC];
    logic [LOG_FRAC-1:0] frac_next [1:LOG_FRAC];
    logic [4:0]        lead;
    logic [30:0]       m_norm;
    logic [28:0]       l_val;
    logic [59:0]       t_prod;
    logic [59:0]       t_round;
    logic              t_valid_reg;
    logic [29:0]       t_reg;
    pgp_side_t         t_side_reg;

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 30; i++)
        begin
            if (in_side.s[i])
            begin
                lead = 5'(i);
            end
        end
        m_norm = 31'({1'b0, in_side.s} << (5'd30 - lead));
    end

    always_comb
    begin
        logic [61:0] sq;
        logic [31:0] top;
        sq = '0;
        top = '0;
        for (int k = 0; k < LOG_FRAC; k++)
        begin
            sq = 62'(m_reg[k]) * 62'(m_reg[k]);
            top = sq[61:30];
            m_next[k+1] = top[31] ? top[31:1] : top[30:0];
            frac_next[k+1] = {frac_reg[k][LOG_FRAC-2:0], top[31]};
        end
    end

    assign l_val = {ip_reg[LOG_FRAC], {LOG_FRAC{1'b0}}} - 29'(frac_reg[LOG_FRAC]);
    assign t_prod = 60'(l_val) * 60'(TWO_LN2_Q30);
    assign t_round = t_prod + 60'(1) * 60'(2**29);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LOG_FRAC; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            t_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= LOG_FRAC; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
            t_valid_reg <= v_reg[LOG_FRAC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= m_norm;
            frac_reg[0] <= '0;
            ip_reg[0] <= 5'd30 - lead;
            side_reg[0] <= in_side;
            for (int k = 1; k <= LOG_FRAC; k++)
            begin
                m_reg[k] <= m_next[k];
                frac_reg[k] <= frac_next[k];
                ip_reg[k] <= ip_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
            t_reg <= t_round[59:30];
            t_side_reg <= side_reg[LOG_FRAC];
        end
    end

    assign out_valid = t_valid_reg;
    assign out_t = t_reg;
    assign out_side = t_side_reg;
endmodule
`default_nettype wire

// ===== sv/pgp_div.sv =====
// two-lane pipelined restoring divider, two quotient bits per stage
`default_nettype none
module pgp_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [1:0][59:0]  in_num,
    input  wire logic [29:0]       in_s,
    input  wire logic [1:0]        in_neg,
    output logic                   out_valid,
    output logic [1:0][61:0]       out_q,
    output logic [1:0]             out_neg
);
    import pgp_pkg::*;

    logic        v_reg   [0:DIV_STAGES];
    logic [29:0] s_reg   [0:DIV_STAGES];
    logic [1:0]  neg_reg [0:DIV_STAGES];
    logic [29:0] rem_reg [0:DIV_STAGES][0:1];
    logic [61:0] st_reg  [0:DIV_STAGES][0:1];
    logic [61:0] q_reg   [0:DIV_STAGES][0:1];
    logic [29:0] rem_next [1:DIV_STAGES][0:1];
    logic [61:0] st_next  [1:DIV_STAGES][0:1];
    logic [61:0] q_next   [1:DIV_STAGES][0:1];

    always_comb
    begin
        logic [30:0] tr;
        logic [29:0] r;
        logic [61:0] st;
        logic [61:0] q;
        tr = '0;
        r = '0;
        st = '0;
        q = '0;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                r = rem_reg[k][l];
                st = st_reg[k][l];
                q = q_reg[k][l];
                for (int j = 0; j < 2; j++)
                begin
                    tr = {r, st[61]};
                    st = {st[60:0], 1'b0};
                    if (tr >= {1'b0, s_reg[k]})
                    begin
                        tr = tr - {1'b0, s_reg[k]};
                        q = {q[60:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[60:0], 1'b0};
                    end
                    r = tr[29:0];
                end
                rem_next[k+1][l] = r;
                st_next[k+1][l] = st;
                q_next[k+1][l] = q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0] <= in_s;
            neg_reg[0] <= in_neg;
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[0][l] <= in_num[l][59:30];
                st_reg[0][l] <= {in_num[l][29:0], 32'b0};
                q_reg[0][l] <= '0;
            end
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                s_reg[k] <= s_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    st_reg[k][l] <= st_next[k][l];
                    q_reg[k][l] <= q_next[k][l];
                end
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES];
    assign out_q[0] = q_reg[DIV_STAGES][0];
    assign out_q[1] = q_reg[DIV_STAGES][1];
    assign out_neg = neg_reg[DIV_STAGES];
endmodule
`default_nettype wire

// ===== sv/pgp_sqrt.sv =====
// two-lane pipelined digit-by-digit integer square root, two root bits per stage (one in the last)
`default_nettype none
module pgp_sqrt (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [1:0][61:0]  in_x,
    input  wire logic [1:0]        in_neg,
    output logic                   out_valid,
    output logic [1:0][30:0]       out_root,
    output logic [1:0]             out_neg
);
    import pgp_pkg::*;

    logic        v_reg    [0:SQRT_STAGES];
    logic [1:0]  neg_reg  [0:SQRT_STAGES];
    logic [61:0] x_reg    [0:SQRT_STAGES][0:1];
    logic [32:0] rem_reg  [0:SQRT_STAGES][0:1];
    logic [30:0] root_reg [0:SQRT_STAGES][0:1];
    logic [61:0] x_next    [1:SQRT_STAGES][0:1];
    logic [32:0] rem_next  [1:SQRT_STAGES][0:1];
    logic [30:0] root_next [1:SQRT_STAGES][0:1];

    always_comb
    begin
        logic [34:0] r;
        logic [34:0] tr;
        logic [61:0] x;
        logic [32:0] rem;
        logic [30:0] root;
        r = '0;
        tr = '0;
        x = '0;
        rem = '0;
        root = '0;
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                x = x_reg[k][l];
                rem = rem_reg[k][l];
                root = root_reg[k][l];
                for (int j = 0; j < 2; j++)
                begin
                    if (2 * k + j < SQRT_ITERS)
                    begin
                        r = {rem, x[61:60]};
                        x = {x[59:0], 2'b00};
                        tr = {2'b00, root, 2'b01};
                        if (r >= tr)
                        begin
                            r = r - tr;
                            root = {root[29:0], 1'b1};
                        end
                        else
                        begin
                            root = {root[29:0], 1'b0};
                        end
                        rem = r[32:0];
                    end
                end
                x_next[k+1][l] = x;
                rem_next[k+1][l] = rem;
                root_next[k+1][l] = root;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SQRT_STAGES; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= SQRT_STAGES; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= in_neg;
            for (int l = 0; l < 2; l++)
            begin
                x_reg[0][l] <= in_x[l];
                rem_reg[0][l] <= '0;
                root_reg[0][l] <= '0;
            end
            for (int k = 1; k <= SQRT_STAGES; k++)
            begin
                neg_reg[k] <= neg_reg[k-1];
                for (int l = 0; l < 2; l++)
                begin
                    x_reg[k][l] <= x_next[k][l];
                    rem_reg[k][l] <= rem_next[k][l];
                    root_reg[k][l] <= root_next[k][l];
                end
            end
        end
    end

    assign out_valid = v_reg[SQRT_STAGES];
    assign out_root[0] = root_reg[SQRT_STAGES][0];
    assign out_root[1] = root_reg[SQRT_STAGES][1];
    assign out_neg = neg_reg[SQRT_STAGES];
endmodule
`default_nettype wire

// ===== sv/polar_gaussian_pair_top.sv =====
// top level of the polar gaussian pair generator
// the pipeline has 79 register stages plus the output register; the second value of a pair
// follows the first as the next output transfer
// the single output channel gives the two values of a pair in turn and stalls the pipeline behind it
// rejected pairs leave the pipeline with no output transaction
// reset clears all valid bits and loads mean 75.0 and deviation 12.0
`default_nettype none
module polar_gaussian_pair_top #(
    parameter int SAMPLE_BITS = pgp_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // uniform_a [15:0], uniform_b [31:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // gauss_value [15:0]
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pgp_pkg::*;

    localparam int EFF_BITS = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
    localparam logic [15:0] SAMPLE_MASK = ~((16'(1) << (16 - EFF_BITS)) - 16'(1));

    logic signed [15:0] mean_reg;
    logic [14:0]        dev_reg;

    logic               en;
    logic signed [15:0] ua;
    logic signed [15:0] ub;
    logic signed [31:0] prod_a;
    logic signed [31:0] prod_b;
    logic [31:0]        ssum;
    logic               in_ok;

    logic               a_valid_reg;
    pgp_side_t          a_side_reg;

    logic               log_valid;
    logic [29:0]        log_t;
    pgp_side_t          log_side;

    logic               n_valid_reg;
    logic [1:0][59:0]   n_num_reg;
    logic [29:0]        n_s_reg;
    logic [1:0]         n_neg_reg;

    logic               div_valid;
    logic [1:0][61:0]   div_q;
    logic [1:0]         div_neg;

    logic               sq_valid;
    logic [1:0][30:0]   sq_root;
    logic [1:0]         sq_neg;

    logic               p_valid_reg;
    logic [1:0][45:0]   p_prod_reg;
    logic [1:0]         p_neg_reg;

    logic               r_valid_reg;
    logic [1:0][15:0]   r_val_reg;
    logic [1:0][15:0]   r_val_next;

    logic               buf_valid_reg;
    logic               buf_phase_reg;
    logic [1:0][15:0]   buf_val_reg;
    logic               buf_free;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DEV) ? {17'b0, dev_reg} : {{16{mean_reg[15]}}, mean_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= MEAN_RESET;
            dev_reg <= DEV_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_MEAN)
            begin
                mean_reg <= pwdata[15:0];
            end
            else
            begin
                dev_reg <= pwdata[14:0];
            end
        end
    end

    // global stall: the pipeline moves unless its last stage is blocked
    assign buf_free = !buf_valid_reg || (buf_phase_reg && m_tready);
    assign en = !(r_valid_reg && !buf_free);
    assign s_tready = en;

    // input stage: precision cut, squares, radius check
    assign ua = s_tdata[15:0] & SAMPLE_MASK;
    assign ub = s_tdata[31:16] & SAMPLE_MASK;
    assign prod_a = ua * ua;
    assign prod_b = ub * ub;
    assign ssum = {1'b0, prod_a[30:0]} + {1'b0, prod_b[30:0]};
    assign in_ok = (ssum != 32'd0) && (ssum < 32'h4000_0000);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_tvalid && in_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg.neg <= {ub[15], ua[15]};
            a_side_reg.sq_a <= prod_a[29:0];
            a_side_reg.sq_b <= prod_b[29:0];
            a_side_reg.s <= ssum[29:0];
        end
    end

    pgp_log u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid_reg),
        .in_side   (a_side_reg),
        .out_valid (log_valid),
        .out_t     (log_t),
        .out_side  (log_side)
    );

    // numerator t * u^2 for both lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            n_valid_reg <= log_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_num_reg[0] <= 60'(log_t) * 60'(log_side.sq_a);
            n_num_reg[1] <= 60'(log_t) * 60'(log_side.sq_b);
            n_s_reg <= log_side.s;
            n_neg_reg <= log_side.neg;
        end
    end

    pgp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n_valid_reg),
        .in_num    (n_num_reg),
        .in_s      (n_s_reg),
        .in_neg    (n_neg_reg),
        .out_valid (div_valid),
        .out_q     (div_q),
        .out_neg   (div_neg)
    );

    pgp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_x      (div_q),
        .in_neg    (div_neg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_neg   (sq_neg)
    );

    // scale by deviation, then round, sign, add mean and saturate
    always_comb
    begin
        logic [46:0]        rnd;
        logic [20:0]        dmag;
        logic signed [20:0] v;
        rnd = '0;
        dmag = '0;
        v = '0;
        for (int l = 0; l < 2; l++)
        begin
            rnd = {1'b0, p_prod_reg[l]} + 47'h800_0000;
            dmag = {2'b00, rnd[46:28]};
            v = 21'(mean_reg) + (p_neg_reg[l] ? -$signed(dmag) : $signed(dmag));
            if (v > 21'sd32767)
            begin
                r_val_next[l] = 16'h7FFF;
            end
            else if (v < -21'sd32768)
            begin
                r_val_next[l] = 16'h8000;
            end
            else
            begin
                r_val_next[l] = v[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= sq_valid;
            r_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_prod_reg[0] <= 46'(dev_reg) * 46'(sq_root[0]);
            p_prod_reg[1] <= 46'(dev_reg) * 46'(sq_root[1]);
            p_neg_reg <= sq_neg;
            r_val_reg <= r_val_next;
        end
    end

    // output register: first value, then second marked last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            buf_phase_reg <= 1'b0;
        end
        else if (r_valid_reg && buf_free)
        begin
            buf_valid_reg <= 1'b1;
            buf_phase_reg <= 1'b0;
        end
        else if (buf_valid_reg && m_tready)
        begin
            if (buf_phase_reg)
            begin
                buf_valid_reg <= 1'b0;
                buf_phase_reg <= 1'b0;
            end
            else
            begin
                buf_phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_valid_reg && buf_free)
        begin
            buf_val_reg <= r_val_reg;
        end
    end

    assign m_tvalid = buf_valid_reg;
    assign m_tdata = buf_phase_reg ? buf_val_reg[1] : buf_val_reg[0];
    assign m_tlast = buf_phase_reg;
endmodule
`default_nettype wire
